@@ rtl/core/t3d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 3-D turtle interpreter package
// Shared types, command codes, symbol bytes and reset values of the turtle.
// ----------------------------------------------------------------------------
package t3d_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int APB_AW          = 3;
    localparam int APB_DW          = 32;

    // Q2.14 unity and register reset values
    localparam logic signed [15:0] ONE_Q14   = 16'sd16384;
    localparam logic signed [15:0] COS_RESET = 16'sd16384;
    localparam logic signed [15:0] SIN_RESET = 16'sd0;

    // Register indexes (word address bit 2)
    localparam logic REG_COS = 1'b0;
    localparam logic REG_SIN = 1'b1;

    // Command bytes
    localparam logic [7:0] SYM_PUSH      = 8'h5B; // '['
    localparam logic [7:0] SYM_POP       = 8'h5D; // ']'
    localparam logic [7:0] SYM_DRAW      = 8'h46; // 'F'
    localparam logic [7:0] SYM_MOVE      = 8'h66; // 'f'
    localparam logic [7:0] SYM_ROLL_POS  = 8'h5C; // backslash
    localparam logic [7:0] SYM_ROLL_NEG  = 8'h2F; // '/'
    localparam logic [7:0] SYM_PITCH_DN  = 8'h26; // '&'
    localparam logic [7:0] SYM_PITCH_UP  = 8'h5E; // '^'
    localparam logic [7:0] SYM_YAW_POS   = 8'h2B; // '+'
    localparam logic [7:0] SYM_YAW_NEG   = 8'h2D; // '-'
    localparam logic [7:0] SYM_TURN      = 8'h7C; // '|'

    localparam logic OP_SYMBOL  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_SEGMENT   = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // Internal command codes
    localparam logic [3:0] CMD_NONE  = 4'd0;
    localparam logic [3:0] CMD_DRAW  = 4'd1;
    localparam logic [3:0] CMD_MOVE  = 4'd2;
    localparam logic [3:0] CMD_ROT   = 4'd3;
    localparam logic [3:0] CMD_FLIP  = 4'd4;
    localparam logic [3:0] CMD_PUSH  = 4'd5;
    localparam logic [3:0] CMD_POP   = 4'd6;
    localparam logic [3:0] CMD_HOME  = 4'd7;
    localparam logic [3:0] CMD_OVF   = 4'd8;
    localparam logic [3:0] CMD_UNF   = 4'd9;

    // Heading pair that a rotation acts on
    localparam logic [1:0] PAIR_HL = 2'd0;
    localparam logic [1:0] PAIR_HU = 2'd1;
    localparam logic [1:0] PAIR_LU = 2'd2;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [15:0] hh;
        logic signed [15:0] hl;
        logic signed [15:0] hu;
    } t_turtle;

    localparam t_turtle TURTLE_HOME = '{
        px: 32'sd0, py: 32'sd0, pz: 32'sd0,
        hh: 16'sd0, hl: ONE_Q14, hu: 16'sd0
    };

endpackage

@@ rtl/core/t3d_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 3-D turtle interpreter channels
// Symbol input channel and segment result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface t3d_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] symbol;

    modport source (output valid, output op, output symbol, input ready);
    modport sink   (input valid, input op, input symbol, output ready);
endinterface

interface t3d_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;

    modport source (output valid, output status, output start_x, output start_y,
                    output start_z, output end_x, output end_y, output end_z,
                    input ready);
    modport sink   (input valid, input status, input start_x, input start_y,
                    input start_z, input end_x, input end_y, input end_z,
                    output ready);
endinterface

@@ rtl/core/t3d_apb_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turn angle register file
// APB-style slave holding the cosine and sine of the turn angle.
// ----------------------------------------------------------------------------
module t3d_apb_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [t3d_pkg::APB_AW-1:0]        paddr,
    input  logic [t3d_pkg::APB_DW-1:0]        pwdata,
    output logic [t3d_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    output logic signed [15:0]                o_cos,
    output logic signed [15:0]                o_sin
);

    logic signed [15:0] r_cos;
    logic signed [15:0] r_sin;
    logic               w_wr;
    logic               w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos <= t3d_pkg::COS_RESET;
            r_sin <= t3d_pkg::SIN_RESET;
        end else if (w_wr) begin
            case (w_idx)
                t3d_pkg::REG_COS: r_cos <= pwdata[15:0];
                t3d_pkg::REG_SIN: r_sin <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            t3d_pkg::REG_COS: prdata = {{(t3d_pkg::APB_DW-16){r_cos[15]}}, r_cos};
            t3d_pkg::REG_SIN: prdata = {{(t3d_pkg::APB_DW-16){r_sin[15]}}, r_sin};
            default:          prdata = '0;
        endcase
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

@@ rtl/core/t3d_stack_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Saved turtle stack memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module t3d_stack_mem #(
    parameter int DEPTH = t3d_pkg::STACK_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  t3d_pkg::t_turtle  i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output t3d_pkg::t_turtle  o_rd_data
);

    t3d_pkg::t_turtle mem [DEPTH];
    t3d_pkg::t_turtle r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/t3d_rotator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heading pair rotator
// Registers the four Q4.28 products, then sums, rounds and saturates to Q2.14.
// ----------------------------------------------------------------------------
module t3d_rotator (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic signed [15:0] i_a,
    input  logic signed [15:0] i_b,
    input  logic signed [15:0] i_cos,
    input  logic signed [15:0] i_sin,
    input  logic               i_neg,
    output logic signed [15:0] o_a,
    output logic signed [15:0] o_b
);

    logic signed [31:0] r_ca;
    logic signed [31:0] r_cb;
    logic signed [31:0] r_sa;
    logic signed [31:0] r_sb;
    logic               r_neg;
    logic signed [32:0] w_sum_a;
    logic signed [32:0] w_sum_b;

    // Add one half, floor by the arithmetic shift, clamp to 16 bits.
    function automatic logic signed [15:0] round_sat(input logic signed [32:0] v);
        logic signed [33:0] t;
        logic signed [19:0] q;
        t = {v[32], v} + 34'sd8192;
        q = t[33:14];
        if (q > 20'sd32767) begin
            return 16'sd32767;
        end else if (q < -20'sd32768) begin
            return -16'sd32768;
        end
        return q[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ca  <= i_cos * i_a;
            r_cb  <= i_cos * i_b;
            r_sa  <= i_sin * i_a;
            r_sb  <= i_sin * i_b;
            r_neg <= i_neg;
        end
    end

    // a' = c*a + s*b, b' = c*b - s*a, with s negated for the reverse turn.
    always_comb begin
        if (r_neg) begin
            w_sum_a = {r_ca[31], r_ca} - {r_sb[31], r_sb};
            w_sum_b = {r_cb[31], r_cb} + {r_sa[31], r_sa};
        end else begin
            w_sum_a = {r_ca[31], r_ca} + {r_sb[31], r_sb};
            w_sum_b = {r_cb[31], r_cb} - {r_sa[31], r_sa};
        end
    end

    assign o_a = round_sat(w_sum_a);
    assign o_b = round_sat(w_sum_b);

endmodule

@@ rtl/core/turtle_3d_interpreter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 3-D turtle interpreter core
// Interprets one L-system command byte per transfer and reports drawn segments.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one command per transfer (op, symbol). op restarts the turtle
//   and empties the stack; otherwise the symbol moves, turns, saves or restores
//   the turtle. o_out carries a result for 'F' (segment start and end) and for
//   a push on a full stack or a pop on an empty one (status, zero coordinates).
//   Every command has two steps: the acceptance cycle issues the rotation
//   multiplies and the stack memory read, the write-back cycle writes the new
//   turtle back. A new command is taken only after the last one is written
//   back. A result enters the output register at the end of the write-back
//   cycle and stays there until it is taken. A command with a result waits
//   at write-back only while an earlier result is still held and the receiver
//   stalls. The turn angle registers are written over the APB-style port;
//   the user must write them only while idle, the block does not enforce it.
//   Reset homes the turtle, empties the stack and loads cosine one, sine zero;
//   the stack memory needs no clearing pass.
// ----------------------------------------------------------------------------
module turtle_3d_interpreter_core #(
    parameter int STACK_DEPTH = t3d_pkg::STACK_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    t3d_in_if.sink                        i_in,
    t3d_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [t3d_pkg::APB_AW-1:0]    paddr,
    input  logic [t3d_pkg::APB_DW-1:0]    pwdata,
    output logic [t3d_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic signed [15:0] w_cos;
    logic signed [15:0] w_sin;

    t3d_pkg::t_turtle   r_cur;
    logic [CW-1:0]      r_cnt;
    logic               r_busy;
    logic [3:0]         r_cmd;
    logic [1:0]         r_pair;

    logic               r_ovalid;
    logic [1:0]         r_status;
    logic signed [31:0] r_sx, r_sy, r_sz, r_ex, r_ey, r_ez;

    logic               w_in_fire;
    logic [3:0]         w_cmd;
    logic [1:0]         w_pair;
    logic               w_neg;
    logic signed [15:0] w_rot_a_in, w_rot_b_in;
    logic signed [15:0] w_rot_a, w_rot_b;
    logic [CW-1:0]      w_cnt_m1;
    logic               w_has_res;
    logic               w_done;
    logic signed [31:0] w_mx, w_my, w_mz;
    t3d_pkg::t_turtle   w_pop_data;

    function automatic logic signed [31:0] sat_move(input logic signed [31:0] p,
                                                    input logic signed [15:0] h);
        logic signed [32:0] s;
        s = {p[31], p} + {{15{h[15]}}, h, 2'b00};
        if (s > 33'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (s < -33'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [15:0] sat_neg(input logic signed [15:0] v);
        if (v == -16'sd32768) begin
            return 16'sd32767;
        end
        return -v;
    endfunction

    t3d_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // ---------------- decode at acceptance ----------------
    assign i_in.ready = !r_busy;
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_cnt_m1   = r_cnt - CW'(1);

    always_comb begin
        w_cmd  = t3d_pkg::CMD_NONE;
        w_pair = t3d_pkg::PAIR_HL;
        w_neg  = 1'b0;
        if (i_in.op == t3d_pkg::OP_RESTART) begin
            w_cmd = t3d_pkg::CMD_HOME;
        end else begin
            case (i_in.symbol)
                t3d_pkg::SYM_PUSH: begin
                    w_cmd = (r_cnt >= CW'(STACK_DEPTH)) ? t3d_pkg::CMD_OVF : t3d_pkg::CMD_PUSH;
                end
                t3d_pkg::SYM_POP: begin
                    w_cmd = (r_cnt == '0) ? t3d_pkg::CMD_UNF : t3d_pkg::CMD_POP;
                end
                t3d_pkg::SYM_DRAW: w_cmd = t3d_pkg::CMD_DRAW;
                t3d_pkg::SYM_MOVE: w_cmd = t3d_pkg::CMD_MOVE;
                t3d_pkg::SYM_ROLL_POS: begin
                    w_cmd = t3d_pkg::CMD_ROT;
                end
                t3d_pkg::SYM_ROLL_NEG: begin
                    w_cmd = t3d_pkg::CMD_ROT;
                    w_neg = 1'b1;
                end
                t3d_pkg::SYM_PITCH_DN: begin
                    w_cmd  = t3d_pkg::CMD_ROT;
                    w_pair = t3d_pkg::PAIR_HU;
                    w_neg  = 1'b1;
                end
                t3d_pkg::SYM_PITCH_UP: begin
                    w_cmd  = t3d_pkg::CMD_ROT;
                    w_pair = t3d_pkg::PAIR_HU;
                end
                t3d_pkg::SYM_YAW_POS: begin
                    w_cmd  = t3d_pkg::CMD_ROT;
                    w_pair = t3d_pkg::PAIR_LU;
                    w_neg  = 1'b1;
                end
                t3d_pkg::SYM_YAW_NEG: begin
                    w_cmd  = t3d_pkg::CMD_ROT;
                    w_pair = t3d_pkg::PAIR_LU;
                end
                t3d_pkg::SYM_TURN: w_cmd = t3d_pkg::CMD_FLIP;
                default:           w_cmd = t3d_pkg::CMD_NONE;
            endcase
        end
    end

    always_comb begin
        case (w_pair)
            t3d_pkg::PAIR_HU: begin
                w_rot_a_in = r_cur.hh;
                w_rot_b_in = r_cur.hu;
            end
            t3d_pkg::PAIR_LU: begin
                w_rot_a_in = r_cur.hl;
                w_rot_b_in = r_cur.hu;
            end
            default: begin
                w_rot_a_in = r_cur.hh;
                w_rot_b_in = r_cur.hl;
            end
        endcase
    end

    t3d_rotator u_rot (
        .i_clk  (i_clk),
        .i_load (w_in_fire),
        .i_a    (w_rot_a_in),
        .i_b    (w_rot_b_in),
        .i_cos  (w_cos),
        .i_sin  (w_sin),
        .i_neg  (w_neg),
        .o_a    (w_rot_a),
        .o_b    (w_rot_b)
    );

    t3d_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (w_done && (r_cmd == t3d_pkg::CMD_PUSH)),
        .i_wr_addr (r_cnt[AW-1:0]),
        .i_wr_data (r_cur),
        .i_rd_en   (w_in_fire && (w_cmd == t3d_pkg::CMD_POP)),
        .i_rd_addr (w_cnt_m1[AW-1:0]),
        .o_rd_data (w_pop_data)
    );

    // ---------------- write-back cycle ----------------
    assign w_has_res = r_cmd inside {t3d_pkg::CMD_DRAW, t3d_pkg::CMD_OVF, t3d_pkg::CMD_UNF};
    assign w_done    = r_busy && (!w_has_res || !r_ovalid || o_out.ready);

    assign w_mx = sat_move(r_cur.px, r_cur.hh);
    assign w_my = sat_move(r_cur.py, r_cur.hu);
    assign w_mz = sat_move(r_cur.pz, r_cur.hl);

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_cmd  <= w_cmd;
            r_pair <= w_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_cur  <= t3d_pkg::TURTLE_HOME;
        end else if (w_in_fire) begin
            r_busy <= 1'b1;
        end else if (w_done) begin
            r_busy <= 1'b0;
            case (r_cmd)
                t3d_pkg::CMD_DRAW, t3d_pkg::CMD_MOVE: begin
                    r_cur.px <= w_mx;
                    r_cur.py <= w_my;
                    r_cur.pz <= w_mz;
                end
                t3d_pkg::CMD_ROT: begin
                    case (r_pair)
                        t3d_pkg::PAIR_HU: begin
                            r_cur.hh <= w_rot_a;
                            r_cur.hu <= w_rot_b;
                        end
                        t3d_pkg::PAIR_LU: begin
                            r_cur.hl <= w_rot_a;
                            r_cur.hu <= w_rot_b;
                        end
                        default: begin
                            r_cur.hh <= w_rot_a;
                            r_cur.hl <= w_rot_b;
                        end
                    endcase
                end
                t3d_pkg::CMD_FLIP: begin
                    r_cur.hl <= sat_neg(r_cur.hl);
                    r_cur.hu <= sat_neg(r_cur.hu);
                end
                t3d_pkg::CMD_PUSH: r_cnt <= r_cnt + CW'(1);
                t3d_pkg::CMD_POP: begin
                    r_cnt <= w_cnt_m1;
                    r_cur <= w_pop_data;
                end
                t3d_pkg::CMD_HOME: begin
                    r_cnt <= '0;
                    r_cur <= t3d_pkg::TURTLE_HOME;
                end
                default: ;
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_done && w_has_res) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && w_has_res) begin
            case (r_cmd)
                t3d_pkg::CMD_DRAW: begin
                    r_status <= t3d_pkg::ST_SEGMENT;
                    r_sx <= r_cur.px;
                    r_sy <= r_cur.py;
                    r_sz <= r_cur.pz;
                    r_ex <= w_mx;
                    r_ey <= w_my;
                    r_ez <= w_mz;
                end
                default: begin
                    r_status <= (r_cmd == t3d_pkg::CMD_OVF) ? t3d_pkg::ST_OVERFLOW
                                                            : t3d_pkg::ST_UNDERFLOW;
                    r_sx <= '0;
                    r_sy <= '0;
                    r_sz <= '0;
                    r_ex <= '0;
                    r_ey <= '0;
                    r_ez <= '0;
                end
            endcase
        end
    end

    assign o_out.valid   = r_ovalid;
    assign o_out.status  = r_status;
    assign o_out.start_x = r_sx;
    assign o_out.start_y = r_sy;
    assign o_out.start_z = r_sz;
    assign o_out.end_x   = r_ex;
    assign o_out.end_y   = r_ey;
    assign o_out.end_z   = r_ez;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(STACK_DEPTH))
        else $error("stack count beyond stack depth");

    a_no_stall_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_ovalid) |=> !r_busy)
        else $error("command held although output register was free");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && (w_cmd == t3d_pkg::CMD_PUSH)) |=> ##1
        (r_cnt == $past(r_cnt, 2) + CW'(1)))
        else $error("push did not advance the stack count");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && (w_cmd == t3d_pkg::CMD_POP)) |=> ##1
        (r_cnt == $past(r_cnt, 2) - CW'(1)))
        else $error("pop did not retire the stack count");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 3-D turtle interpreter core testbench
// Drives command bytes into the core, mirrors the turtle and its stack in a
// local model, and compares every segment and stack error the core reports.
// Covers all commands, stack limits, heading saturation, several turn angles,
// random idle gaps on both channels and a long output stall.
// ----------------------------------------------------------------------------
module tb_top;
    import t3d_pkg::*;

    localparam int STACK_DEPTH    = STACK_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int MAX_REPORTS    = 100;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [31:0] ez;
    } t_segment;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    t3d_in_if  in_if ();
    t3d_out_if out_if ();

    turtle_3d_interpreter_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Turtle model state
    logic signed [15:0] turn_cos;
    logic signed [15:0] turn_sin;
    t_turtle            turtle;
    t_turtle            saved_stack [STACK_DEPTH];
    int unsigned        saved_count;
    t_segment           pending_results [$];
    t_segment           want;

    int err_count;
    int quiet_cycles;
    bit tx_idle_on;
    bit rx_idle_on;
    int rx_gap;
    int rx_hold_cycles;
    int string_depth;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model arithmetic
    // ------------------------------------------------------------------------
    function automatic logic signed [15:0] sat16(input longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic logic signed [31:0] step_axis(input logic signed [31:0] p,
                                                     input logic signed [15:0] h);
        longint sum;
        sum = longint'(p) + longint'(h) * 4;
        if (sum > 64'sd2147483647) return 32'sh7fffffff;
        if (sum < -64'sd2147483648) return 32'sh80000000;
        return sum[31:0];
    endfunction

    // Q4.28 to Q2.14 with round half up; the arithmetic shift floors.
    function automatic logic signed [15:0] round_q14(input longint v);
        return sat16((v + 8192) >>> 14);
    endfunction

    function automatic void rotate_pair(input logic signed [15:0] a,
                                        input logic signed [15:0] b,
                                        input longint c, input longint s,
                                        output logic signed [15:0] a_n,
                                        output logic signed [15:0] b_n);
        longint a0;
        longint b0;
        a0 = a;
        b0 = b;
        a_n = round_q14(c * a0 + s * b0);
        b_n = round_q14(c * b0 - s * a0);
    endfunction

    function automatic void move_turtle();
        turtle.px = step_axis(turtle.px, turtle.hh);
        turtle.py = step_axis(turtle.py, turtle.hu);
        turtle.pz = step_axis(turtle.pz, turtle.hl);
    endfunction

    function automatic void add_expected(input t_segment seg);
        pending_results.insert(pending_results.size(), seg);
    endfunction

    task automatic interpret_symbol(input logic op, input logic [7:0] sym);
        t_segment seg;
        longint   c;
        longint   s;
        c = turn_cos;
        s = turn_sin;
        seg = '0;
        if (op == OP_RESTART) begin
            turtle = TURTLE_HOME;
            saved_count = 0;
        end else begin
            case (sym)
                SYM_PUSH: begin
                    if (saved_count >= STACK_DEPTH) begin
                        seg.status = ST_OVERFLOW;
                        add_expected(seg);
                    end else begin
                        saved_stack[saved_count] = turtle;
                        saved_count++;
                    end
                end
                SYM_POP: begin
                    if (saved_count == 0) begin
                        seg.status = ST_UNDERFLOW;
                        add_expected(seg);
                    end else begin
                        saved_count--;
                        turtle = saved_stack[saved_count];
                    end
                end
                SYM_DRAW: begin
                    seg.status = ST_SEGMENT;
                    seg.sx = turtle.px;
                    seg.sy = turtle.py;
                    seg.sz = turtle.pz;
                    move_turtle();
                    seg.ex = turtle.px;
                    seg.ey = turtle.py;
                    seg.ez = turtle.pz;
                    add_expected(seg);
                end
                SYM_MOVE:     move_turtle();
                SYM_ROLL_POS: rotate_pair(turtle.hh, turtle.hl, c, s, turtle.hh, turtle.hl);
                SYM_ROLL_NEG: rotate_pair(turtle.hh, turtle.hl, c, -s, turtle.hh, turtle.hl);
                SYM_PITCH_DN: rotate_pair(turtle.hh, turtle.hu, c, -s, turtle.hh, turtle.hu);
                SYM_PITCH_UP: rotate_pair(turtle.hh, turtle.hu, c, s, turtle.hh, turtle.hu);
                SYM_YAW_POS:  rotate_pair(turtle.hl, turtle.hu, c, -s, turtle.hl, turtle.hu);
                SYM_YAW_NEG:  rotate_pair(turtle.hl, turtle.hu, c, s, turtle.hl, turtle.hu);
                SYM_TURN: begin
                    turtle.hl = sat16(-longint'(turtle.hl));
                    turtle.hu = sat16(-longint'(turtle.hu));
                end
                default: ;
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitors
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input longint want_v,
                                        input longint got_v);
        if (want_v != got_v) begin
            if (err_count < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want_v, got_v);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            interpret_symbol(in_if.op, in_if.symbol);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                if (err_count < MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, out_if.status);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status",  want.status, out_if.status);
                check_field("start_x", want.sx, out_if.start_x);
                check_field("start_y", want.sy, out_if.start_y);
                check_field("start_z", want.sz, out_if.start_z);
                check_field("end_x",   want.ex, out_if.end_x);
                check_field("end_y",   want.ey, out_if.end_y);
                check_field("end_z",   want.ez, out_if.end_z);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("** turtle_3d_interpreter_core: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result receiver; a requested hold is counted here, independent of the sender.
    always begin
        @(negedge i_clk);
        if (rx_hold_cycles > 0) begin
            out_if.ready <= 1'b0;
            repeat (rx_hold_cycles) @(negedge i_clk);
            rx_hold_cycles = 0;
        end else if (rx_gap > 0) begin
            out_if.ready <= 1'b0;
            rx_gap--;
        end else begin
            out_if.ready <= 1'b1;
            if (rx_idle_on) rx_gap = pick_gap();
        end
    end

    // Entered and left just after a falling edge; valid stays high on return,
    // so the caller either sends again or lowers it in the same step.
    task automatic send_command(input logic op, input logic [7:0] sym);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.op     <= op;
        in_if.symbol <= sym;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        // Commands without a result may still be in flight.
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_turn_reg(input logic reg_sel, input logic signed [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {{16{value[15]}}, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_COS) turn_cos = value;
        else turn_sin = value;
    endtask

    task automatic set_turn(input logic signed [15:0] c, input logic signed [15:0] s);
        wait_idle();
        write_turn_reg(REG_COS, c);
        @(negedge i_clk);
        write_turn_reg(REG_SIN, s);
    endtask

    function automatic logic [7:0] pick_turn_symbol();
        case ($urandom_range(0, 5))
            0: return SYM_ROLL_POS;
            1: return SYM_ROLL_NEG;
            2: return SYM_PITCH_DN;
            3: return SYM_PITCH_UP;
            4: return SYM_YAW_POS;
            default: return SYM_YAW_NEG;
        endcase
    endfunction

    // Mostly bracketed strings with random content, plus restarts and noise bytes.
    task automatic send_random_item();
        int         r;
        logic [7:0] sym;
        r = $urandom_range(0, 99);
        sym = 8'($urandom_range(0, 255));
        if (r < 4) begin
            send_command(OP_RESTART, sym);
            string_depth = 0;
        end else if (r < 12) begin
            send_command(OP_SYMBOL, sym);
        end else begin
            if (r < 35) sym = SYM_DRAW;
            else if (r < 42) sym = SYM_MOVE;
            else if (r < 65) sym = pick_turn_symbol();
            else if (r < 69) sym = SYM_TURN;
            else if (r < 83) sym = SYM_PUSH;
            else sym = SYM_POP;
            if (sym == SYM_POP && string_depth == 0 && $urandom_range(0, 3) != 0)
                sym = SYM_PUSH;
            if (sym == SYM_PUSH && string_depth < STACK_DEPTH) string_depth++;
            else if (sym == SYM_POP && string_depth > 0) string_depth--;
            send_command(OP_SYMBOL, sym);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_home_commands();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_command(OP_SYMBOL, SYM_POP);
        send_command(OP_SYMBOL, SYM_DRAW);
        send_command(OP_SYMBOL, SYM_MOVE);
        send_command(OP_SYMBOL, SYM_DRAW);
        send_command(OP_SYMBOL, SYM_TURN);
        send_command(OP_SYMBOL, SYM_DRAW);
        send_command(OP_SYMBOL, 8'h00);
        send_command(OP_SYMBOL, 8'hFF);
        send_command(OP_RESTART, SYM_DRAW);
        send_command(OP_SYMBOL, SYM_DRAW);
        send_command(OP_SYMBOL, SYM_PUSH);
        send_command(OP_RESTART, 8'h00);
        send_command(OP_SYMBOL, SYM_POP);
    endtask

    task automatic test_turn_commands();
        set_turn(16'sd0, 16'sd16384);
        send_command(OP_RESTART, 8'hFF);
        send_command(OP_SYMBOL, SYM_ROLL_POS);
        send_command(OP_SYMBOL, SYM_DRAW);
        send_command(OP_SYMBOL, SYM_ROLL_NEG);
        send_command(OP_SYMBOL, SYM_PITCH_DN);
        send_command(OP_SYMBOL, SYM_DRAW);
        send_command(OP_SYMBOL, SYM_PITCH_UP);
        send_command(OP_SYMBOL, SYM_YAW_POS);
        send_command(OP_SYMBOL, SYM_DRAW);
        send_command(OP_SYMBOL, SYM_YAW_NEG);
        send_command(OP_SYMBOL, SYM_DRAW);
        // With cosine and sine both one, l is driven to -32768 and then negated.
        set_turn(16'sd16384, 16'sd16384);
        send_command(OP_RESTART, 8'h00);
        send_command(OP_SYMBOL, SYM_TURN);
        send_command(OP_SYMBOL, SYM_YAW_POS);
        send_command(OP_SYMBOL, SYM_YAW_NEG);
        send_command(OP_SYMBOL, SYM_TURN);
        send_command(OP_SYMBOL, SYM_DRAW);
        // Two rolls push h past the Q2.14 range.
        send_command(OP_RESTART, 8'h00);
        send_command(OP_SYMBOL, SYM_YAW_POS);
        send_command(OP_SYMBOL, SYM_ROLL_POS);
        send_command(OP_SYMBOL, SYM_ROLL_POS);
        send_command(OP_SYMBOL, SYM_DRAW);
    endtask

    task automatic test_stack_limits();
        int i;
        set_turn(16'sd11585, 16'sd11585);
        send_command(OP_RESTART, 8'h00);
        for (i = 0; i < STACK_DEPTH; i++) begin
            send_command(OP_SYMBOL, SYM_DRAW);
            send_command(OP_SYMBOL, pick_turn_symbol());
            send_command(OP_SYMBOL, SYM_PUSH);
        end
        send_command(OP_SYMBOL, SYM_PUSH);
        send_command(OP_SYMBOL, SYM_DRAW);
        for (i = 0; i < STACK_DEPTH; i++) begin
            send_command(OP_SYMBOL, SYM_POP);
            send_command(OP_SYMBOL, SYM_DRAW);
        end
        send_command(OP_SYMBOL, SYM_POP);
    endtask

    task automatic test_output_backpressure();
        int i;
        wait_idle();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        rx_hold_cycles = 250;
        for (i = 0; i < 40; i++) begin
            send_command(OP_SYMBOL, (i % 3 == 2) ? SYM_YAW_POS : SYM_DRAW);
        end
    endtask

    task automatic test_random_strings();
        int                 phase;
        logic signed [15:0] c;
        logic signed [15:0] s;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin c = 16'sd15137;  s = 16'sd6270;   end
                1: begin c = 16'sd11585;  s = -16'sd11585; end
                2: begin c = -16'sd16384; s = 16'sd16384;  end
                3: begin c = 16'sd0;      s = -16'sd16384; end
                default: begin
                    c = 16'($signed($urandom_range(0, 32768)) - 16384);
                    s = 16'($signed($urandom_range(0, 32768)) - 16384);
                end
            endcase
            set_turn(c, s);
            tx_idle_on = (phase != 2);
            rx_idle_on = (phase != 3);
            string_depth = 0;
            send_command(OP_RESTART, 8'h00);
            repeat (100) send_random_item();
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.op       = OP_SYMBOL;
        in_if.symbol   = 8'h00;
        out_if.ready   = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        turn_cos       = COS_RESET;
        turn_sin       = SIN_RESET;
        turtle         = TURTLE_HOME;
        saved_count    = 0;
        err_count      = 0;
        quiet_cycles   = 0;
        tx_idle_on     = 1'b0;
        rx_idle_on     = 1'b0;
        rx_gap         = 0;
        rx_hold_cycles = 0;
        string_depth   = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_home_commands();
        test_turn_commands();
        test_stack_limits();
        test_output_backpressure();
        test_random_strings();

        wait_idle();
        if (err_count == 0) begin
            $display("** turtle_3d_interpreter_core: PASSED **");
        end else begin
            $display("** turtle_3d_interpreter_core: FAILED **");
        end
        $finish;
    end

endmodule
